[sv/tbww_pkg.sv]
// ----------------------------------------------------------------------------
// tbww_pkg
// Shared types, constants and helpers for the text box word wrap block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbww_pkg;

	// Word buffer depth and line spacing in pixels
	localparam int WORD_DEPTH = 32;
	localparam int LINE_PITCH = 10;

	localparam int ADDR_W  = $clog2(WORD_DEPTH);
	localparam int CNT_W   = $clog2(WORD_DEPTH + 1);
	localparam int CHAR_W  = 8;
	localparam int CWID_W  = 6;
	localparam int COORD_W = 11;
	localparam int BOX_W   = 9;
	localparam int OFF_W   = 10;
	localparam int PIX_W   = 11;
	localparam int PITCH_W = 6;

	localparam logic [PITCH_W-1:0] PITCH     = PITCH_W'(LINE_PITCH);
	localparam logic [PIX_W-1:0]   PIXEL_MAX = '1;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	// Configuration register indexes
	localparam logic [1:0] REG_BOX_LEFT   = 2'd0;
	localparam logic [1:0] REG_BOX_TOP    = 2'd1;
	localparam logic [1:0] REG_BOX_WIDTH  = 2'd2;
	localparam logic [1:0] REG_BOX_HEIGHT = 2'd3;

	// Reset values of the box registers
	localparam logic [COORD_W-1:0] BOX_LEFT_RST   = '0;
	localparam logic [COORD_W-1:0] BOX_TOP_RST    = '0;
	localparam logic [BOX_W-1:0]   BOX_WIDTH_RST  = BOX_W'(320);
	localparam logic [BOX_W-1:0]   BOX_HEIGHT_RST = BOX_W'(240);

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [BOX_W-1:0]   width;
		logic [BOX_W-1:0]   height;
	} cfg_t;

	// One buffered character
	typedef struct packed {
		logic [CWID_W-1:0] width;
		logic [CHAR_W-1:0] code;
	} word_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		word_t             wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} ram_req_t;

	// Printed character payload
	typedef struct packed {
		logic [COORD_W-1:0] pos_y;
		logic [COORD_W-1:0] pos_x;
		logic [CHAR_W-1:0]  code;
	} pay_t;

	typedef struct packed {
		logic trunc;
		logic full;
		logic last;
		pay_t pay;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAYOUT,
		ST_CHECK,
		ST_FLUSH
	} st_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CHAR_NUL) || (c == CHAR_SPACE) || (c == CHAR_TAB);
	endfunction

endpackage

`default_nettype wire

[sv/text_box_word_wrap.sv]
// ----------------------------------------------------------------------------
// text_box_word_wrap
// Greedy word wrap of a character stream into a text box.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one character and its pixel width per transaction.
// Output stream (m_axis): one transaction per printed character with its
// screen position; tlast marks the final character of a word, tuser carries
// the box-full and word-truncated flags.
// Configuration (cfg_*): box origin, width and height; users write them only while idle, unchecked by the block.
// Sequencing: a character inside a word is appended to the word buffer,
// then the early-break check runs; a flush state follows when the early
// break fills the box. A whitespace that closes a word starts a walk of
// the buffer memory, one entry per cycle while the output buffer takes
// results, then the check and, with a result pending, a flush that
// releases the final result. Input is ignored while the box is full, until NUL.
// Reset clears all wrap state; the word buffer memory needs no clearing.
// A stalled receiver fills the two-entry output buffer and then holds the
// layout walk; input is taken again once the current word is done.
// ----------------------------------------------------------------------------
`default_nettype none

module text_box_word_wrap (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // char_code[7:0], char_width[13:8]
	// Output stream
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [31:0] m_axis_tdata,   // out_char[7:0], pos_x[18:8], pos_y[29:19]
	output      logic        m_axis_tlast,
	output      logic [1:0]  m_axis_tuser,   // box_full[0], word_truncated[1]
	// Configuration writes
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);
	import tbww_pkg::*;

	cfg_t     cfg_q;
	ram_req_t ram_req;
	word_t    ram_rd_data;
	logic     fifo_push;
	logic     fifo_ready;
	res_t     fifo_in;
	res_t     fifo_out;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left   <= BOX_LEFT_RST;
			cfg_q.top    <= BOX_TOP_RST;
			cfg_q.width  <= BOX_WIDTH_RST;
			cfg_q.height <= BOX_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BOX_LEFT:   cfg_q.left   <= cfg_data[COORD_W-1:0];
				REG_BOX_TOP:    cfg_q.top    <= cfg_data[COORD_W-1:0];
				REG_BOX_WIDTH:  cfg_q.width  <= cfg_data[BOX_W-1:0];
				REG_BOX_HEIGHT: cfg_q.height <= cfg_data[BOX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tbww_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_code     (s_axis_tdata[7:0]),
		.in_width    (s_axis_tdata[13:8]),
		.ram_req     (ram_req),
		.ram_rd_data (ram_rd_data),
		.fifo_push   (fifo_push),
		.fifo_data   (fifo_in),
		.fifo_ready  (fifo_ready)
	);

	tbww_word_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_rd_data)
	);

	tbww_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fifo_push),
		.in_ready  (fifo_ready),
		.in_data   (fifo_in),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (fifo_out)
	);

	// Output packing
	assign m_axis_tdata = {2'b00, fifo_out.pay.pos_y, fifo_out.pay.pos_x, fifo_out.pay.code};
	assign m_axis_tlast = fifo_out.last;
	assign m_axis_tuser = {fifo_out.trunc, fifo_out.full};

endmodule

`default_nettype wire

[sv/tbww_word_ram.sv]
// ----------------------------------------------------------------------------
// tbww_word_ram
// Word buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbww_word_ram (
	input  wire logic              clk,
	input  wire tbww_pkg::ram_req_t req,
	output      tbww_pkg::word_t   rd_data
);
	import tbww_pkg::*;

	word_t mem [WORD_DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

[sv/tbww_out_fifo.sv]
// ----------------------------------------------------------------------------
// tbww_out_fifo
// Two-entry result buffer between the sequencer and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tbww_out_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	input  wire tbww_pkg::res_t in_data,
	output      logic           out_valid,
	input  wire logic           out_ready,
	output      tbww_pkg::res_t out_data
);
	import tbww_pkg::*;

	res_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rd_ptr_q];
	assign do_wr     = in_valid && in_ready;
	assign do_rd     = out_valid && out_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= in_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/tbww_ctrl.sv]
// ----------------------------------------------------------------------------
// tbww_ctrl
// Word wrap sequencer: appends characters to the word buffer, walks the
// buffer to lay out a finished word, and applies the early line break.
// ----------------------------------------------------------------------------
`default_nettype none

module tbww_ctrl (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tbww_pkg::cfg_t                     cfg,
	input  wire logic                               in_valid,
	output      logic                               in_ready,
	input  wire logic [tbww_pkg::CHAR_W-1:0]        in_code,
	input  wire logic [tbww_pkg::CWID_W-1:0]        in_width,
	output      tbww_pkg::ram_req_t                 ram_req,
	input  wire tbww_pkg::word_t                    ram_rd_data,
	output      logic                               fifo_push,
	output      tbww_pkg::res_t                     fifo_data,
	input  wire logic                               fifo_ready
);
	import tbww_pkg::*;

	st_t state_q, state_d;

	// Per-item registers
	logic [CHAR_W-1:0] c_q;
	logic [CWID_W-1:0] w_q;
	logic              stop_q;
	logic              trunc_q;
	logic [ADDR_W-1:0] i_q;
	pay_t              pend_q;
	logic              pend_valid_q;

	// Wrap state
	logic [CNT_W-1:0]  count_q;
	logic [PIX_W-1:0]  pix_q;
	logic [OFF_W-1:0]  x_q;
	logic [OFF_W-1:0]  y_q;
	logic              in_word_q;
	logic              halted_q;
	logic              ovf_q;

	logic              acc;
	logic              go_layout;
	logic              buf_room;
	logic [PIX_W:0]    pix_sum;
	logic [OFF_W:0]    y_inc;
	logic              y_over;

	logic              lay_skip;
	logic              lay_wrap;
	logic              lay_stop;
	logic              lay_emit;
	logic              lay_stall;
	logic              lay_end;
	logic              lay_go;
	logic [OFF_W-1:0]  lay_xs;
	logic [OFF_W-1:0]  lay_y_n;
	pay_t              lay_res;

	logic [PIX_W:0]    chk_sum;
	logic              chk_brk;
	logic              stop_all;

	assign acc       = in_valid && in_ready;
	assign go_layout = in_word_q && is_space(in_code);
	assign buf_room  = (count_q < CNT_W'(WORD_DEPTH));
	assign pix_sum   = {1'b0, pix_q} + (PIX_W + 1)'(in_width);
	assign y_inc     = {1'b0, y_q} + (OFF_W + 1)'(PITCH);
	assign y_over    = (y_inc > (OFF_W + 1)'(cfg.height));

	// Layout of one buffered character
	assign lay_skip  = (x_q == '0) && is_space(ram_rd_data.code);
	assign lay_wrap  = (x_q > OFF_W'(cfg.width));
	assign lay_y_n   = lay_wrap ? y_inc[OFF_W-1:0] : y_q;
	assign lay_stop  = !lay_skip && lay_wrap && y_over;
	assign lay_emit  = !lay_skip && !lay_stop;
	assign lay_xs    = lay_wrap ? '0 : x_q;
	assign lay_stall = lay_emit && pend_valid_q && !fifo_ready;
	assign lay_end   = lay_stop || ((CNT_W'(i_q) + CNT_W'(1)) == count_q);
	assign lay_go    = (state_q == ST_LAYOUT) && !lay_stall;

	assign lay_res.code  = ram_rd_data.code;
	assign lay_res.pos_x = cfg.left + COORD_W'(lay_xs);
	assign lay_res.pos_y = cfg.top + COORD_W'(lay_y_n);

	// Early break: the word would overflow this line but fits a fresh one
	assign chk_sum  = (PIX_W + 1)'(x_q) + (PIX_W + 1)'(pix_q);
	assign chk_brk  = !stop_q && (c_q != CHAR_NUL)
		&& (chk_sum > (PIX_W + 1)'(cfg.width)) && (pix_q < PIX_W'(cfg.width));
	assign stop_all = stop_q || (chk_brk && y_over);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && !halted_q) begin
					state_d = go_layout ? ST_LAYOUT : ST_CHECK;
				end
			end
			ST_LAYOUT: begin
				if (lay_go && lay_end) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = (stop_all || pend_valid_q) ? ST_FLUSH : ST_IDLE;
			end
			ST_FLUSH: begin
				if (fifo_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake, memory requests, result pushes
	always_comb begin
		in_ready          = 1'b0;
		ram_req.wr_en     = 1'b0;
		ram_req.wr_addr   = '0;
		ram_req.wr_data   = '{width: in_width, code: in_code};
		ram_req.rd_en     = 1'b0;
		ram_req.rd_addr   = '0;
		fifo_push         = 1'b0;
		fifo_data.trunc   = trunc_q;
		fifo_data.full    = 1'b0;
		fifo_data.last    = 1'b0;
		fifo_data.pay     = pend_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (acc && !halted_q) begin
					if (go_layout) begin
						ram_req.rd_en = 1'b1;
					end else if (buf_room) begin
						ram_req.wr_en   = 1'b1;
						ram_req.wr_addr = count_q[ADDR_W-1:0];
					end
				end
			end
			ST_LAYOUT: begin
				if (lay_go) begin
					fifo_push       = lay_emit && pend_valid_q;
					ram_req.rd_en   = !lay_end;
					ram_req.rd_addr = i_q + ADDR_W'(1);
					// Delimiter opens the next word
					ram_req.wr_en   = lay_end;
					ram_req.wr_data = '{width: w_q, code: c_q};
				end
			end
			ST_CHECK: begin
			end
			ST_FLUSH: begin
				fifo_push      = fifo_ready;
				fifo_data.last = 1'b1;
				fifo_data.full = stop_q;
			end
			default: begin
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			c_q <= in_code;
			w_q <= in_width;
		end
		if (lay_go && lay_emit) begin
			pend_q <= lay_res;
		end else if (state_q == ST_CHECK && stop_all && !pend_valid_q) begin
			pend_q <= '0;
		end
	end

	// Wrap state and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q       <= 1'b0;
			trunc_q      <= 1'b0;
			i_q          <= '0;
			pend_valid_q <= 1'b0;
			count_q      <= '0;
			pix_q        <= '0;
			x_q          <= '0;
			y_q          <= '0;
			in_word_q    <= 1'b0;
			halted_q     <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						stop_q <= 1'b0;
						i_q    <= '0;
						if (halted_q) begin
							if (in_code == CHAR_NUL) begin
								count_q   <= '0;
								pix_q     <= '0;
								x_q       <= '0;
								y_q       <= '0;
								in_word_q <= 1'b0;
								halted_q  <= 1'b0;
								ovf_q     <= 1'b0;
							end
						end else if (go_layout) begin
							trunc_q <= ovf_q;
						end else begin
							in_word_q <= 1'b1;
							if (buf_room) begin
								count_q <= count_q + CNT_W'(1);
								pix_q   <= pix_sum[PIX_W] ? PIXEL_MAX : pix_sum[PIX_W-1:0];
								trunc_q <= ovf_q;
							end else begin
								ovf_q   <= 1'b1;
								trunc_q <= 1'b1;
							end
						end
					end
				end
				ST_LAYOUT: begin
					if (lay_go) begin
						i_q <= i_q + ADDR_W'(1);
						if (lay_stop) begin
							x_q    <= '0;
							y_q    <= lay_y_n;
							stop_q <= 1'b1;
						end else if (lay_emit) begin
							x_q          <= lay_xs + OFF_W'(ram_rd_data.width);
							y_q          <= lay_y_n;
							pend_valid_q <= 1'b1;
						end
						if (lay_end) begin
							ovf_q     <= 1'b0;
							in_word_q <= 1'b0;
							pix_q     <= '0;
							count_q   <= CNT_W'(1);
						end
					end
				end
				ST_CHECK: begin
					if (chk_brk) begin
						x_q <= '0;
						y_q <= y_inc[OFF_W-1:0];
					end
					stop_q <= stop_all;
					if (stop_all) begin
						halted_q     <= 1'b1;
						pend_valid_q <= 1'b1;
					end else if (!pend_valid_q && c_q == CHAR_NUL) begin
						count_q   <= '0;
						pix_q     <= '0;
						x_q       <= '0;
						y_q       <= '0;
						in_word_q <= 1'b0;
						halted_q  <= 1'b0;
						ovf_q     <= 1'b0;
					end
				end
				ST_FLUSH: begin
					if (fifo_ready) begin
						pend_valid_q <= 1'b0;
						if (c_q == CHAR_NUL) begin
							count_q   <= '0;
							pix_q     <= '0;
							x_q       <= '0;
							y_q       <= '0;
							in_word_q <= 1'b0;
							halted_q  <= 1'b0;
							ovf_q     <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// No result is left pending between items
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("pending result left over in idle");

	// A push always carries a pending result
	a_push_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> pend_valid_q && fifo_ready)
		else $error("result pushed without pending data");

	// A layout walk only runs over an open, non-empty word
	a_layout_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAYOUT |-> in_word_q && count_q != '0)
		else $error("layout started without a buffered word");

	// Buffer fill never passes its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WORD_DEPTH))
		else $error("word buffer count overrun");

endmodule

`default_nettype wire

[verif/text_box_word_wrap_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_box_word_wrap_tb
// Self-checking bench for the greedy word wrap block. Directed and random text
// streams of words and separators go in, with the output side stalled at
// random in most phases. A layout model in the scoreboard predicts every drawn
// glyph, and each output transaction is compared with it field by field.
// ----------------------------------------------------------------------------

module text_box_word_wrap_tb;
	import tbww_pkg::*;

	// Layout model plus the queue of glyphs still to be drawn
	class wrap_scoreboard;
		cfg_t             box;
		logic [CHAR_W-1:0] buf_code [WORD_DEPTH];
		logic [CWID_W-1:0] buf_wid [WORD_DEPTH];
		int               buf_len;
		int               run_pixels;
		int               line_x;
		int               line_y;
		bit               in_run;
		bit               halted;
		bit               dropped;
		res_t             glyphs[$];
		int               errors;

		function new();
			box.left   = BOX_LEFT_RST;
			box.top    = BOX_TOP_RST;
			box.width  = BOX_WIDTH_RST;
			box.height = BOX_HEIGHT_RST;
			errors = 0;
			clear_text();
		endfunction

		function void clear_text();
			buf_len    = 0;
			run_pixels = 0;
			line_x     = 0;
			line_y     = 0;
			in_run     = 0;
			halted     = 0;
			dropped    = 0;
		endfunction

		function bit is_blank(logic [CHAR_W-1:0] c);
			return (c == CHAR_NUL) || (c == CHAR_SPACE) || (c == CHAR_TAB);
		endfunction

		function void set_reg(logic [1:0] idx, logic [10:0] data);
			case (idx)
				REG_BOX_LEFT:   box.left   = data;
				REG_BOX_TOP:    box.top    = data;
				REG_BOX_WIDTH:  box.width  = data[BOX_W-1:0];
				REG_BOX_HEIGHT: box.height = data[BOX_W-1:0];
				default: ;
			endcase
		endfunction

		function int glyphs_waiting();
			return glyphs.size();
		endfunction

		// Takes one accepted character; returns 0 when the block ignores it
		function bit place_char(logic [CHAR_W-1:0] code, logic [CWID_W-1:0] wid);
			res_t drawn [WORD_DEPTH + 1];
			int   n;
			bit   stop;
			bit   trunc;
			int   limit_x;
			int   limit_y;

			n       = 0;
			stop    = 0;
			trunc   = 0;
			limit_x = int'(box.width);
			limit_y = int'(box.height);

			// box full: only NUL does anything
			if (halted) begin
				if (code == CHAR_NUL)
					clear_text();
				return 0;
			end

			if (in_run && is_blank(code)) begin
				// lay out the buffered run
				for (int i = 0; i < buf_len; i++) begin
					if (line_x == 0 && is_blank(buf_code[i]))
						continue;
					if (line_x > limit_x) begin
						line_x = 0;
						line_y += LINE_PITCH;
						if (line_y > limit_y) begin
							stop = 1;
							break;
						end
					end
					drawn[n]           = '0;
					drawn[n].pay.code  = buf_code[i];
					drawn[n].pay.pos_x = box.left + COORD_W'(line_x);
					drawn[n].pay.pos_y = box.top + COORD_W'(line_y);
					n++;
					line_x += int'(buf_wid[i]);
				end
				trunc       = dropped;
				dropped     = 0;
				in_run      = 0;
				run_pixels  = 0;
				buf_code[0] = code;
				buf_wid[0]  = wid;
				buf_len     = 1;
			end else begin
				// append, or drop when the buffer is full
				in_run = 1;
				if (buf_len < WORD_DEPTH) begin
					buf_code[buf_len] = code;
					buf_wid[buf_len]  = wid;
					buf_len++;
					run_pixels += int'(wid);
					if (run_pixels > int'(PIXEL_MAX))
						run_pixels = int'(PIXEL_MAX);
				end else begin
					dropped = 1;
				end
				trunc = dropped;
			end

			// early line break when the run would overflow but fits a fresh line
			if (!stop && code != CHAR_NUL) begin
				if (line_x + run_pixels > limit_x && run_pixels < limit_x) begin
					line_x = 0;
					line_y += LINE_PITCH;
					if (line_y > limit_y)
						stop = 1;
				end
			end

			if (stop) begin
				halted = 1;
				if (n == 0) begin
					drawn[0] = '0;
					n = 1;
				end
				drawn[n-1].full = 1'b1;
			end
			if (n > 0)
				drawn[n-1].last = 1'b1;
			for (int k = 0; k < n; k++) begin
				drawn[k].trunc = trunc;
				glyphs.push_back(drawn[k]);
			end

			if (code == CHAR_NUL)
				clear_text();
			return 1;
		endfunction

		task report(string what);
			errors++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		// Compares one output transaction with the oldest predicted glyph
		task check_glyph(logic [31:0] data, logic last, logic [1:0] user);
			res_t want;

			if (glyphs.size() == 0) begin
				report($sformatf("unexpected glyph %h", data));
				return;
			end
			want = glyphs.pop_front();
			if (data[7:0] != want.pay.code)
				report($sformatf("out_char %h, want %h", data[7:0], want.pay.code));
			if (data[18:8] != want.pay.pos_x)
				report($sformatf("pos_x %h, want %h", data[18:8], want.pay.pos_x));
			if (data[29:19] != want.pay.pos_y)
				report($sformatf("pos_y %h, want %h", data[29:19], want.pay.pos_y));
			if (last != want.last)
				report($sformatf("last_of_run %b, want %b", last, want.last));
			if (user[0] != want.full)
				report($sformatf("box_full %b, want %b", user[0], want.full));
			if (user[1] != want.trunc)
				report($sformatf("word_truncated %b, want %b", user[1], want.trunc));
		endtask
	endclass

	localparam int LIMIT_CYCLES  = 400000;
	localparam int QUIET_CYCLES  = 100;
	localparam int SETTLE_LIMIT  = 20000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	wrap_scoreboard sb = new();
	int snd_idle = 33;
	int rcv_idle = 69;
	bit hold_rx = 1'b0;
	int cycles = 0;

	text_box_word_wrap dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Output side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
				hold_rx = 1'b0;
			end
			m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	// Check every output transaction
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_glyph(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	// Watchdog
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("text_box_word_wrap_tb: FAIL");
		$finish;
	end

	// Offer one character; live is 0 when the block ignores it
	task send_char(input logic [7:0] code, input logic [5:0] wid, output bit live);
		while ($urandom_range(0, 99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, wid, code};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		live = sb.place_char(code, wid);
	endtask

	// Write all four box registers, block idle
	task write_box(input logic [10:0] left, input logic [10:0] top,
			input logic [10:0] width, input logic [10:0] height);
		logic [10:0] vals [4];
		logic [1:0]  idx [4];

		vals[0] = left;   idx[0] = REG_BOX_LEFT;
		vals[1] = top;    idx[1] = REG_BOX_TOP;
		vals[2] = width;  idx[2] = REG_BOX_WIDTH;
		vals[3] = height; idx[3] = REG_BOX_HEIGHT;
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= vals[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.set_reg(idx[k], vals[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for all predicted glyphs, then let the block go quiet
	task settle();
		int guard;

		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (sb.glyphs_waiting() != 0 && guard < SETTLE_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (sb.glyphs_waiting() != 0) begin
			sb.report($sformatf("%0d glyphs never drawn", sb.glyphs_waiting()));
			sb.glyphs.delete();
		end
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	function logic [5:0] pick_width();
		if ($urandom_range(0, 99) < 75)
			return 6'($urandom_range(0, 15));
		return 6'($urandom_range(0, 63));
	endfunction

	// Random text: mostly words and separators, some NULs, some noise
	task run_text(input int target);
		int          counted;
		int          len;
		int          seps;
		logic [7:0]  c;
		bit          live;

		counted = 0;
		while (counted < target) begin
			if ($urandom_range(0, 99) < 82) begin
				len = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 40) :
					$urandom_range(1, 8);
				for (int j = 0; j < len; j++) begin
					do
						c = 8'($urandom_range(1, 255));
					while (c == CHAR_SPACE || c == CHAR_TAB);
					send_char(c, pick_width(), live);
					counted++;
				end
				seps = $urandom_range(1, 2);
				for (int j = 0; j < seps; j++) begin
					c = $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
					send_char(c, pick_width(), live);
					counted++;
				end
				if ($urandom_range(0, 99) < 10) begin
					send_char(CHAR_NUL, pick_width(), live);
					counted++;
				end
			end else begin
				send_char(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), live);
				counted++;
			end
		end
	endtask

	initial begin
		logic [7:0] dir_code [$];
		logic [5:0] dir_wid [$];
		bit         live;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset box: words closed by blanks and NUL, leading blank skip
		dir_code = '{8'h41, 8'hFF, 8'h61, CHAR_SPACE, 8'h42, CHAR_SPACE, 8'h43, 8'h44,
			CHAR_NUL, CHAR_TAB, 8'h01, CHAR_SPACE};
		dir_wid  = '{6'd63, 6'd63, 6'd1, 6'd0, 6'd30, 6'd3, 6'd40, 6'd63,
			6'd0, 6'd5, 6'd1, 6'd2};
		foreach (dir_code[k])
			send_char(dir_code[k], dir_wid[k], live);
		settle();

		// Directed, tiny box with an origin away from zero: early break, stops and halting
		write_box(11'h400, 11'h3FF, 11'd20, 11'd10);
		dir_code = '{8'h46, CHAR_SPACE, 8'h47, 8'h48, CHAR_SPACE, 8'h49, 8'h4A, CHAR_NUL,
			8'h4B, CHAR_TAB, 8'h4C, 8'h4D, CHAR_SPACE, CHAR_NUL};
		dir_wid  = '{6'd20, 6'd0, 6'd10, 6'd5, 6'd1, 6'd10, 6'd7, 6'd63,
			6'd30, 6'd0, 6'd25, 6'd25, 6'd0, 6'd0};
		foreach (dir_code[k])
			send_char(dir_code[k], dir_wid[k], live);
		settle();

		// Random phases over several box settings and idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				snd_idle = 33;
				rcv_idle = 69;
			end else if (ph < 4) begin
				snd_idle = 69;
				rcv_idle = 33;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			case (ph)
				0: write_box(11'h3FF, 11'h400, 11'h7FF, 11'h1FF);
				1: write_box(11'h000, 11'h000, 11'h600, 11'h600);
				default: write_box(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
					{2'($urandom_range(0, 3)), 9'($urandom_range(16, 200))},
					{2'($urandom_range(0, 3)), 9'($urandom_range(20, 120))});
			endcase
			// fill the block while the output is held off
			if (ph == 4)
				hold_rx = 1'b1;
			run_text(PHASE_ITEMS);
			send_char(CHAR_NUL, 6'd0, live);
			settle();
		end

		if (sb.errors == 0)
			$display("text_box_word_wrap_tb: PASS");
		else
			$display("text_box_word_wrap_tb: FAIL");
		$finish;
	end

endmodule

[text_box_word_wrap.f]
sv/tbww_pkg.sv
sv/tbww_word_ram.sv
sv/tbww_out_fifo.sv
sv/tbww_ctrl.sv
sv/text_box_word_wrap.sv
verif/text_box_word_wrap_tb.sv
